// ----- rtl/core/sha_pkg.sv -----
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types and constants of the slab heap allocator.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int unsigned PAGE_BYTES    = 4096;
    localparam int unsigned SMALL_CLASSES = 9;
    localparam int unsigned ADDR_PAGES    = 256;

    localparam logic [3:0] KIND_UNUSED = 4'd0;
    localparam logic [3:0] KIND_BIG    = 4'd10;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ZERO    = 3'd1;
    localparam logic [2:0] ST_EXHAUST = 3'd2;
    localparam logic [2:0] ST_IGNORED = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // per-page record
    typedef struct packed {
        logic [3:0] kind;
        logic [8:0] top;   // word index of top free cell, 0 when empty
        logic [8:0] next;  // next page in class plus one
        logic [8:0] bp;    // big block page count
    } t_page_rec;

    typedef struct packed {
        logic       en;
        logic [7:0] page;
        t_page_rec  rec;
    } t_rec_wr;

    typedef struct packed {
        logic       en;
        logic [7:0] page;
        logic [8:0] word;
        logic [8:0] data;
    } t_link_wr;

    typedef struct packed {
        logic [7:0] page;
        logic [8:0] np;
    } t_big_ent;

endpackage

// ----- rtl/core/sha_if.sv -----
// ----------------------------------------------------------------------------
// sha_if
// Valid/ready channels of the slab heap allocator.
// ----------------------------------------------------------------------------
interface sha_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [20:0] request_bytes;
    logic [19:0] block_address;
    modport source (output valid, operation, request_bytes, block_address, input ready);
    modport sink   (input valid, operation, request_bytes, block_address, output ready);
endinterface

interface sha_rsp_if;
    logic        valid;
    logic        ready;
    logic [19:0] granted_address;
    logic [2:0]  status;
    modport source (output valid, granted_address, status, input ready);
    modport sink   (input valid, granted_address, status, output ready);
endinterface

interface sha_cfg_if;
    logic       valid;
    logic       ready;
    logic [8:0] heap_limit_pages;
    modport source (output valid, heap_limit_pages, input ready);
    modport sink   (input valid, heap_limit_pages, output ready);
endinterface

// ----- rtl/core/sha_page_store.sv -----
// ----------------------------------------------------------------------------
// sha_page_store
// Page record memory with valid bits, and the cell link memory.
// ----------------------------------------------------------------------------
module sha_page_store #(
    parameter int PAGES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_rec_rd_page,
    output sha_pkg::t_page_rec o_rec,
    input  sha_pkg::t_rec_wr  i_rec_wr,
    input  logic [7:0]        i_link_rd_page,
    input  logic [8:0]        i_link_rd_word,
    output logic [8:0]        o_link,
    input  sha_pkg::t_link_wr i_link_wr
);
    import sha_pkg::*;

    localparam int PW = $clog2(PAGES);

    t_page_rec  r_rec_mem [PAGES];
    logic [8:0] r_link_mem [PAGES*512];
    logic [PAGES-1:0] r_vld;
    t_page_rec  r_rec;
    logic       r_rec_vld;
    logic [8:0] r_link;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_rec_wr.en) begin
            r_vld[i_rec_wr.page[PW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rec_wr.en) begin
            r_rec_mem[i_rec_wr.page[PW-1:0]] <= i_rec_wr.rec;
        end
        r_rec     <= r_rec_mem[i_rec_rd_page[PW-1:0]];
        r_rec_vld <= r_vld[i_rec_rd_page[PW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_link_wr.en) begin
            r_link_mem[{i_link_wr.page[PW-1:0], i_link_wr.word}] <= i_link_wr.data;
        end
        r_link <= r_link_mem[{i_link_rd_page[PW-1:0], i_link_rd_word}];
    end

    // never-written page reads as unused
    always_comb begin
        o_rec = r_rec;
        if (!r_rec_vld) o_rec.kind = KIND_UNUSED;
    end
    assign o_link = r_link;

endmodule

// ----- rtl/core/sha_big_table.sv -----
// ----------------------------------------------------------------------------
// sha_big_table
// Best-fit table of free big blocks, one read and one write port.
// ----------------------------------------------------------------------------
module sha_big_table #(
    parameter int BIG_TABLE_ENTRIES = 16
) (
    input  logic                                 i_clk,
    input  logic [$clog2(BIG_TABLE_ENTRIES)-1:0] i_rd_idx,
    output sha_pkg::t_big_ent                    o_rd,
    input  logic                                 i_wr_en,
    input  logic [$clog2(BIG_TABLE_ENTRIES)-1:0] i_wr_idx,
    input  sha_pkg::t_big_ent                    i_wr_ent
);
    import sha_pkg::*;

    t_big_ent r_mem [BIG_TABLE_ENTRIES];
    t_big_ent r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_mem[i_wr_idx] <= i_wr_ent;
        r_rd <= r_mem[i_rd_idx];
    end

    assign o_rd = r_rd;

endmodule

// ----- rtl/core/slab_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// slab_heap_allocator
// Paged heap with power-of-two small classes and a best-fit big block table.
// ----------------------------------------------------------------------------
//  channel  dir  carries
//  i_req    in   operation, request_bytes, block_address
//  o_rsp    out  granted_address, status
//  i_cfg    in   heap_limit_pages (always ready)
//
//  One item at a time; ready only while the sequencer is idle.
//  Small alloc from a listed page reads the page record, then the link of its
//  top cell; carving a fresh page first links its cells, one per cycle (508 for
//  8-byte cells down to 1 for 2048-byte cells), bound by the single write port
//  of the cell link memory. Big alloc/free scan the table, then shift entries.
//  Reset is synchronous; page records are tracked by valid bits, no clearing
//  pass. A waiting result blocks only the end of the next item.
// ----------------------------------------------------------------------------
module slab_heap_allocator #(
    parameter int HEAP_PAGES        = 256,
    parameter int BIG_TABLE_ENTRIES = 16
) (
    input logic       i_clk,
    input logic       i_rst_n,
    sha_req_if.sink   i_req,
    sha_rsp_if.source o_rsp,
    sha_cfg_if.sink   i_cfg
);
    import sha_pkg::*;

    // pages reachable by a 20-bit address
    localparam int NPG = (HEAP_PAGES < ADDR_PAGES) ? HEAP_PAGES : ADDR_PAGES;
    localparam int BT  = BIG_TABLE_ENTRIES;
    localparam int BI  = $clog2(BT);
    localparam int BW  = BI + 1;

    typedef enum logic [4:0] {
        S_IDLE, S_DEC, S_CARVE, S_PW, S_PR, S_LW, S_LR, S_FW, S_FR,
        S_FB_RD, S_FB_CMP, S_SH, S_SH_W, S_BA_RD, S_BA_CMP, S_RM, S_RM_W, S_DONE
    } t_state;

    t_state      r_state;
    logic        r_op;
    logic [20:0] r_req;
    logic [19:0] r_addr;
    logic [3:0]  r_c;
    logic [7:0]  r_p;
    logic [8:0]  r_top;
    logic [8:0]  r_cnt;
    logic [8:0]  r_sz;
    logic [BW-1:0] r_i, r_j, r_pos, r_bcount;
    logic        r_posf;
    logic [8:0]  r_bump;
    logic [8:0]  r_limit;
    logic [8:0]  r_cls [SMALL_CLASSES];
    t_page_rec   r_orec;
    logic [19:0] r_grant;
    logic [2:0]  r_stat;
    logic        r_ovalid;
    logic [19:0] r_ogrant;
    logic [2:0]  r_ostat;

    t_page_rec  pg_rec;
    logic [8:0] pg_link;
    t_rec_wr    rec_wr;
    t_link_wr   link_wr;
    t_big_ent   big_rd;
    logic [BI-1:0] big_rd_idx;
    logic       big_wr_en;
    logic [BI-1:0] big_wr_idx;
    t_big_ent   big_wr_ent;

    // ---- helpers ----
    function automatic logic [4:0] bit_len(input logic [20:0] v);
        logic [4:0] n;
        n = 5'd0;
        for (int k = 0; k < 21; k++) begin
            if (v[k]) n = 5'(k + 1);
        end
        return n;
    endfunction

    function automatic logic [8:0] cells_of(input logic [3:0] c);
        return 9'(12'd4064 >> (4'd3 + c));
    endfunction

    // ---- derived values ----
    logic [4:0]  dec_cl;
    logic [3:0]  dec_c;
    logic        dec_small;
    logic [19:0] dec_adj;
    logic [8:0]  lim;
    logic [3:0]  fr_c;
    logic [11:0] fr_off, fr_rel, fr_mask;
    logic        fr_small, fr_ok;
    logic [8:0]  cv_n, cv_w, cv_nx;
    logic        cv_last;
    logic [21:0] ba_size;
    logic [10:0] ba_pages;
    logic        ba_fits;

    always_comb begin
        dec_cl    = bit_len(r_req - 21'd1);
        dec_c     = (dec_cl <= 5'd3) ? 4'd0 : 4'(dec_cl - 5'd3);
        dec_small = (r_req <= 21'd2048);
        dec_adj   = (r_addr[11:0] == 12'd0) ? (r_addr - 20'd1) : r_addr;
        lim       = (r_limit > 9'(NPG)) ? 9'(NPG) : r_limit;

        fr_c     = pg_rec.kind - 4'd1;
        fr_small = (pg_rec.kind >= 4'd1) && (pg_rec.kind <= 4'(SMALL_CLASSES));
        fr_off   = r_addr[11:0];
        fr_rel   = fr_off - 12'd32;
        fr_mask  = (12'd8 << fr_c) - 12'd1;
        fr_ok    = (fr_off >= 12'd32) && ((fr_rel & fr_mask) == 12'd0)
                   && (9'(fr_rel >> (4'd3 + fr_c)) < cells_of(fr_c));

        cv_n    = cells_of(r_c);
        cv_w    = 9'(10'd4 + (10'(r_cnt) << r_c));
        cv_last = (r_cnt == cv_n - 9'd1);
        cv_nx   = cv_last ? 9'd0 : 9'(10'(cv_w) + (10'd1 << r_c));

        ba_size  = {1'b0, big_rd.np, 12'd0} - 22'd96;
        ba_pages = 11'((22'(r_req) + 22'd96) >> 12) + 11'd1;
        ba_fits  = (11'(r_bump) + ba_pages) <= 11'(lim);
    end

    // ---- memory port drive ----
    always_comb begin
        rec_wr      = '0;
        link_wr     = '0;
        big_wr_en   = 1'b0;
        big_wr_idx  = r_j[BI-1:0];
        big_wr_ent  = big_rd;
        big_rd_idx  = r_i[BI-1:0];
        unique case (r_state)
            S_CARVE: begin
                link_wr = '{en: 1'b1, page: r_p, word: cv_w, data: cv_nx};
                if (cv_last) begin
                    rec_wr.en   = 1'b1;
                    rec_wr.page = r_p;
                    rec_wr.rec  = '{kind: 4'd1 + r_c, top: 9'd4, next: r_cls[r_c], bp: 9'd0};
                end
            end
            S_LR: begin
                rec_wr.en      = 1'b1;
                rec_wr.page    = r_p;
                rec_wr.rec     = r_orec;
                rec_wr.rec.top = pg_link;
                if (pg_link == 9'd0) rec_wr.rec.next = 9'd0;
            end
            S_FR: begin
                if (fr_small && fr_ok) begin
                    link_wr = '{en: 1'b1, page: r_p, word: fr_off[11:3], data: pg_rec.top};
                    rec_wr.en      = 1'b1;
                    rec_wr.page    = r_p;
                    rec_wr.rec     = pg_rec;
                    rec_wr.rec.top = fr_off[11:3];
                    if (pg_rec.top == 9'd0) rec_wr.rec.next = r_cls[fr_c];
                end
            end
            S_BA_RD: begin
                if (r_i == r_bcount && ba_fits) begin
                    rec_wr.en   = 1'b1;
                    rec_wr.page = r_bump[7:0];
                    rec_wr.rec  = '{kind: KIND_BIG, top: 9'd0, next: 9'd0,
                                    bp: ba_pages[8:0]};
                end
            end
            S_SH: begin
                big_rd_idx = BI'(r_j - BW'(1));
                if (r_j == r_pos) begin
                    big_wr_en  = 1'b1;
                    big_wr_idx = r_pos[BI-1:0];
                    big_wr_ent = '{page: r_p, np: r_sz};
                end
            end
            S_SH_W: begin
                big_wr_en = 1'b1;
            end
            S_RM: begin
                big_rd_idx = BI'(r_j + BW'(1));
            end
            S_RM_W: begin
                big_wr_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    sha_page_store #(.PAGES(NPG)) u_pages (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rec_rd_page  (r_p),
        .o_rec          (pg_rec),
        .i_rec_wr       (rec_wr),
        .i_link_rd_page (r_p),
        .i_link_rd_word (r_top),
        .o_link         (pg_link),
        .i_link_wr      (link_wr)
    );

    sha_big_table #(.BIG_TABLE_ENTRIES(BT)) u_big (
        .i_clk    (i_clk),
        .i_rd_idx (big_rd_idx),
        .o_rd     (big_rd),
        .i_wr_en  (big_wr_en),
        .i_wr_idx (big_wr_idx),
        .i_wr_ent (big_wr_ent)
    );

    assign i_req.ready           = (r_state == S_IDLE);
    assign i_cfg.ready           = 1'b1;
    assign o_rsp.valid           = r_ovalid;
    assign o_rsp.granted_address = r_ogrant;
    assign o_rsp.status          = r_ostat;

    // ---- sequencer ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_bcount <= '0;
            r_bump   <= 9'd0;
            r_limit  <= 9'd256;
            for (int k = 0; k < SMALL_CLASSES; k++) r_cls[k] <= 9'd0;
        end else begin
            if (i_cfg.valid) r_limit <= i_cfg.heap_limit_pages;
            // S_DONE reloads the output register itself
            if (o_rsp.ready && r_state != S_DONE) r_ovalid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op    <= i_req.operation;
                        r_req   <= i_req.request_bytes;
                        r_addr  <= i_req.block_address;
                        r_grant <= 20'd0;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (r_op == OP_ALLOC) begin
                        if (r_req == 21'd0) begin
                            r_stat  <= ST_ZERO;
                            r_state <= S_DONE;
                        end else if (dec_small) begin
                            r_c <= dec_c;
                            if (r_cls[dec_c] != 9'd0) begin
                                r_p     <= 8'(r_cls[dec_c] - 9'd1);
                                r_state <= S_PW;
                            end else if (r_bump >= lim) begin
                                r_stat  <= ST_EXHAUST;
                                r_state <= S_DONE;
                            end else begin
                                r_p     <= r_bump[7:0];
                                r_cnt   <= 9'd0;
                                r_state <= S_CARVE;
                            end
                        end else begin
                            r_i     <= '0;
                            r_state <= S_BA_RD;
                        end
                    end else begin
                        r_addr <= dec_adj;
                        r_p    <= dec_adj[19:12];
                        if (r_addr == 20'd0) begin
                            r_stat  <= ST_OK;
                            r_state <= S_DONE;
                        end else if (9'(dec_adj[19:12]) >= 9'(NPG)) begin
                            r_stat  <= ST_IGNORED;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_FW;
                        end
                    end
                end
                // link one cell per cycle, top of stack at word 4
                S_CARVE: begin
                    r_cnt <= r_cnt + 9'd1;
                    if (cv_last) begin
                        r_cls[r_c] <= 9'(r_p) + 9'd1;
                        r_bump     <= r_bump + 9'd1;
                        r_state    <= S_PW;
                    end
                end
                S_PW: r_state <= S_PR;
                S_PR: begin
                    r_orec  <= pg_rec;
                    r_top   <= pg_rec.top;
                    r_state <= S_LW;
                end
                S_LW: r_state <= S_LR;
                S_LR: begin
                    if (pg_link == 9'd0) r_cls[r_c] <= r_orec.next;
                    r_grant <= {r_p, r_top, 3'b000};
                    r_stat  <= ST_OK;
                    r_state <= S_DONE;
                end
                S_FW: r_state <= S_FR;
                S_FR: begin
                    if (fr_small) begin
                        if (fr_ok && pg_rec.top == 9'd0) r_cls[fr_c] <= 9'(r_p) + 9'd1;
                        r_stat  <= fr_ok ? ST_OK : ST_IGNORED;
                        r_state <= S_DONE;
                    end else if (pg_rec.kind == KIND_BIG) begin
                        r_sz    <= pg_rec.bp;
                        r_i     <= '0;
                        r_posf  <= 1'b0;
                        r_state <= S_FB_RD;
                    end else begin
                        r_stat  <= ST_IGNORED;
                        r_state <= S_DONE;
                    end
                end
                // duplicate check and insert position in one pass
                S_FB_RD: begin
                    if (r_i == r_bcount) begin
                        if (r_bcount >= BW'(BT)) begin
                            r_stat  <= ST_FULL;
                            r_state <= S_DONE;
                        end else begin
                            if (!r_posf) r_pos <= r_bcount;
                            r_j     <= r_bcount;
                            r_state <= S_SH;
                        end
                    end else begin
                        r_state <= S_FB_CMP;
                    end
                end
                S_FB_CMP: begin
                    if (big_rd.page == r_p) begin
                        r_stat  <= ST_IGNORED;
                        r_state <= S_DONE;
                    end else begin
                        if (!r_posf && big_rd.np >= r_sz) begin
                            r_pos  <= r_i;
                            r_posf <= 1'b1;
                        end
                        r_i     <= r_i + BW'(1);
                        r_state <= S_FB_RD;
                    end
                end
                S_SH: begin
                    if (r_j == r_pos) begin
                        r_bcount <= r_bcount + BW'(1);
                        r_stat   <= ST_OK;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_SH_W;
                    end
                end
                S_SH_W: begin
                    r_j     <= r_j - BW'(1);
                    r_state <= S_SH;
                end
                S_BA_RD: begin
                    if (r_i == r_bcount) begin
                        if (ba_fits) begin
                            r_grant <= {r_bump[7:0], 12'd96};
                            r_bump  <= 9'(11'(r_bump) + ba_pages);
                            r_stat  <= ST_OK;
                        end else begin
                            r_stat  <= ST_EXHAUST;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_BA_CMP;
                    end
                end
                S_BA_CMP: begin
                    if (ba_size >= {1'b0, r_req}) begin
                        r_p     <= big_rd.page;
                        r_j     <= r_i;
                        r_state <= S_RM;
                    end else begin
                        r_i     <= r_i + BW'(1);
                        r_state <= S_BA_RD;
                    end
                end
                // close the gap left by the taken entry
                S_RM: begin
                    if (r_j + BW'(1) < r_bcount) begin
                        r_state <= S_RM_W;
                    end else begin
                        r_bcount <= r_bcount - BW'(1);
                        r_grant  <= {r_p, 12'd96};
                        r_stat   <= ST_OK;
                        r_state  <= S_DONE;
                    end
                end
                S_RM_W: begin
                    r_j     <= r_j + BW'(1);
                    r_state <= S_RM;
                end
                S_DONE: begin
                    if (!r_ovalid || o_rsp.ready) begin
                        r_ovalid <= 1'b1;
                        r_ogrant <= r_grant;
                        r_ostat  <= r_stat;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
